[src/chcf_pkg.sv]
// Shared definitions for the compass heading complementary filter.
// Holds widths, fixed-point constants, the arctangent table and state types.
// No dependencies; every other file of the block imports this package.
package chcf_pkg;

    // Iteration count of the vectoring CORDIC, limited to the table length.
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITER  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // Field and register widths.
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int WEIGHT_W    = 17;
    localparam int HEAD_W      = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // Internal datapath widths.
    localparam int AXIS_W   = 44;   // scaled axes with CORDIC growth
    localparam int ANG_W    = 24;   // angle in 1/16384 degree, signed
    localparam int ATAN_W   = 20;
    localparam int MUL_A_W  = 31;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = MUL_A_W;
    localparam int DIFF_W   = 18;
    localparam int ACC_W    = 48;
    localparam int UNIT_SHIFT = 25;
    localparam int QUOT_W   = ACC_W - UNIT_SHIFT;
    localparam int RED_W    = 21;
    localparam int RED_CNT_W = 2;
    localparam int CSCALE_W = HEAD_W + 12;
    localparam int AXIS_SHIFT  = 8;
    localparam int FINE_SHIFT  = 8;
    localparam int RECIP_SHIFT = 18;

    // Angle constants in 1/16384 degree and 1/64 degree.
    localparam logic signed [ANG_W-1:0] DEG180_FINE = 24'sd2949120;
    localparam logic signed [ANG_W-1:0] DEG360_FINE = 24'sd5898240;
    localparam logic signed [ANG_W-1:0] FINE_HALF   = 24'sd128;
    localparam logic [HEAD_W-1:0]       DEG360_Q64  = 15'd23040;

    // Blend constants: 57.3 * 160, unit/2, weight of one.
    localparam logic signed [MUL_B_W-1:0] RATE_FACTOR = 18'sd9168;
    localparam logic signed [ACC_W-1:0]   HALF_UNIT   = 48'sd83886080;
    localparam logic [WEIGHT_W-1:0]       WEIGHT_ONE  = 17'd65536;

    // Modulo reduction: the rounded quotient is offset to be non-negative and
    // reduced by 115200 (five full circles of 1/64 degree), then divided by five.
    localparam logic [RED_W-1:0]          RED_OFFSET = 21'd921600;
    localparam logic [RED_W-1:0]          RED_MOD    = 21'd115200;
    localparam logic signed [MUL_B_W-1:0] RECIP5     = 18'sd52429;

    // atan(2^-i) in degrees times 16384, rounded to nearest.
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
        20'd14667,  20'd7334,   20'd3667,   20'd1833,   20'd917,   20'd458,
        20'd229,    20'd115,    20'd57,     20'd29,     20'd14,    20'd7,
        20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
    };

    // Reset values of the configuration registers.
    localparam logic signed [SAMPLE_W-1:0] MAG_X_OFFSET_RST = 16'sd855;
    localparam logic [GAIN_W-1:0]          MAG_X_GAIN_RST   = 16'd19980;
    localparam logic signed [SAMPLE_W-1:0] MAG_Y_OFFSET_RST = -16'sd274;
    localparam logic [GAIN_W-1:0]          MAG_Y_GAIN_RST   = 16'd22756;
    localparam logic signed [SAMPLE_W-1:0] GYRO_BIAS_RST    = 16'sd51;
    localparam logic [WEIGHT_W-1:0]        GYRO_WEIGHT_RST  = 17'd13107;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAG_X_OFFSET = 3'd0,
        REG_MAG_X_GAIN   = 3'd1,
        REG_MAG_Y_OFFSET = 3'd2,
        REG_MAG_Y_GAIN   = 3'd3,
        REG_GYRO_BIAS    = 3'd4,
        REG_GYRO_WEIGHT  = 3'd5
    } chcf_reg_t;

    // Main sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_CSTART,
        ST_CWAIT,
        ST_MUL_GYRO,
        ST_MUL_COMP,
        ST_ROUND,
        ST_REDUCE,
        ST_DIV5,
        ST_DONE
    } chcf_state_t;

    // CORDIC unit states.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_WRAP,
        CS_ROUND
    } cordic_state_t;

    // Request into the CORDIC unit and its result.
    typedef struct packed {
        logic                     start;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
    } cordic_req_t;

    typedef struct packed {
        logic              done;
        logic [HEAD_W-1:0] heading;
    } cordic_res_t;

endpackage

[src/chcf_sample_if.sv]
// Sample channel: magnetometer X/Y and gyro Z rate with a valid/ready handshake.
// Depends on chcf_pkg for the field widths.
interface chcf_sample_if;
    import chcf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mag_x;
    logic signed [SAMPLE_W-1:0] mag_y;
    logic signed [SAMPLE_W-1:0] gyro_rate;

    modport source (output valid, output mag_x, output mag_y, output gyro_rate, input ready);
    modport sink   (input valid, input mag_x, input mag_y, input gyro_rate, output ready);
endinterface

[src/chcf_result_if.sv]
// Result channel: filtered and compass headings with a valid/ready handshake.
// Depends on chcf_pkg for the field widths.
interface chcf_result_if;
    import chcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] filtered_heading;
    logic [HEAD_W-1:0] compass_heading;

    modport source (output valid, output filtered_heading, output compass_heading, input ready);
    modport sink   (input valid, input filtered_heading, input compass_heading, output ready);
endinterface

[src/chcf_cfg_if.sv]
// Configuration write channel: register index and write data with valid/ready.
// Depends on chcf_pkg for the index and data widths.
interface chcf_cfg_if;
    import chcf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/chcf_cordic.sv]
// Iterative vectoring CORDIC: one shift-add micro-rotation per cycle,
// followed by a wrap state and a rounding/mirroring state. Depends on chcf_pkg.
module chcf_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  chcf_pkg::cordic_req_t req,
    output chcf_pkg::cordic_res_t res
);
    import chcf_pkg::*;

    cordic_state_t            state_reg, state_next;
    logic signed [AXIS_W-1:0] x_reg, x_next;
    logic signed [AXIS_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     zero_reg, zero_next;

    logic signed [AXIS_W-1:0] x_sh;
    logic signed [AXIS_W-1:0] y_sh;
    logic signed [ANG_W-1:0]  atan_ext;
    logic signed [ANG_W-1:0]  z_round;
    logic [HEAD_W-1:0]        angle_q64;
    logic                     last_step;

    // Shifted operands and table entry for the current micro-rotation.
    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign atan_ext  = $signed(ANG_W'(ATAN_TAB[step_reg]));
    assign last_step = (step_reg == STEP_W'(CORDIC_ITER - 1));

    // Round the wrapped angle to 1/64 degree, half up.
    assign z_round   = z_reg + FINE_HALF;
    assign angle_q64 = z_round[FINE_SHIFT +: HEAD_W];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (req.start)
                begin
                    state_next = CS_ITER;
                end
            end
            CS_ITER:
            begin
                if (last_step)
                begin
                    state_next = CS_WRAP;
                end
            end
            CS_WRAP:  state_next = CS_ROUND;
            CS_ROUND: state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    // Result: the heading is the mirrored angle, with a full circle or a zero input vector taken as zero.
    always_comb
    begin
        res.done    = (state_reg == CS_ROUND);
        res.heading = '0;
        if (!zero_reg && angle_q64 != '0 && angle_q64 != DEG360_Q64)
        begin
            res.heading = DEG360_Q64 - angle_q64;
        end
    end

    // Datapath: load with half-plane fold, rotate, then wrap into one circle.
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        zero_next = zero_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (req.start)
                begin
                    zero_next = (req.x == '0) && (req.y == '0);
                    step_next = '0;
                    if (req.x < 0)
                    begin
                        x_next = -req.x;
                        y_next = -req.y;
                        z_next = DEG180_FINE;
                    end
                    else
                    begin
                        x_next = req.x;
                        y_next = req.y;
                        z_next = '0;
                    end
                end
            end
            CS_ITER:
            begin
                if (!y_reg[AXIS_W-1])
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_ext;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_ext;
                end
                step_next = step_reg + STEP_W'(1);
            end
            CS_WRAP:
            begin
                if (z_reg[ANG_W-1])
                begin
                    z_next = z_reg + DEG360_FINE;
                end
                else if (z_reg >= DEG360_FINE)
                begin
                    z_next = z_reg - DEG360_FINE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        zero_reg <= zero_next;
    end

endmodule

[src/compass_heading_complementary_filter_core.sv]
// Top level of the compass heading complementary filter.
// Depends on chcf_pkg, the three channel interfaces and chcf_cordic.
//
// Each sample request carries magnetometer X/Y and a gyro Z rate and yields one
// result request with the blended heading and the magnetometer-only heading, both
// in 1/64 degree (0 to 23039). The block takes one sample at a time: it is ready
// only while idle, and a sample occupies it through the axis scalings, the CORDIC
// run and, but for the first sample after reset, which only primes the kept
// heading, the blend. The CORDIC unit performs its micro-rotations in turn and
// then wraps and rounds, and the one shared 31x18 multiplier computes both axis
// scalings, the rate conversion, both blend products and the final divide by
// five in turn, with a restoring modulo reduction between. A finished result
// waits in an output register, so a new sample is taken while it is still
// pending; only the hand-over into that register waits for the result channel.
// Configuration writes are always accepted and should be made while no sample
// is in flight.
module compass_heading_complementary_filter_core (
    input  logic       clk,
    input  logic       rst_n,
    chcf_sample_if.sink  sample,
    chcf_result_if.source result,
    chcf_cfg_if.sink     cfg
);
    import chcf_pkg::*;

    // Configuration registers.
    logic signed [SAMPLE_W-1:0] mag_x_offset_reg, mag_x_offset_next;
    logic [GAIN_W-1:0]          mag_x_gain_reg, mag_x_gain_next;
    logic signed [SAMPLE_W-1:0] mag_y_offset_reg, mag_y_offset_next;
    logic [GAIN_W-1:0]          mag_y_gain_reg, mag_y_gain_next;
    logic signed [SAMPLE_W-1:0] gyro_bias_reg, gyro_bias_next;
    logic [WEIGHT_W-1:0]        gyro_weight_reg, gyro_weight_next;

    // Sequencer and filter state.
    chcf_state_t       state_reg, state_next;
    logic [HEAD_W-1:0] kept_reg, kept_next;
    logic              primed_reg, primed_next;

    // Sample and working registers.
    logic signed [SAMPLE_W-1:0] mag_x_reg, mag_x_next;
    logic signed [SAMPLE_W-1:0] mag_y_reg, mag_y_next;
    logic signed [SAMPLE_W-1:0] rate_reg, rate_next;
    logic signed [AXIS_W-1:0]   xs_reg, xs_next;
    logic signed [AXIS_W-1:0]   ys_reg, ys_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [RED_W-1:0]           red_reg, red_next;
    logic [RED_CNT_W-1:0]       red_cnt_reg, red_cnt_next;
    logic [HEAD_W-1:0]          comp_reg, comp_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [HEAD_W-1:0] out_filt_reg, out_filt_next;
    logic [HEAD_W-1:0] out_comp_reg, out_comp_next;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    // Control and helper signals.
    logic                        accept;
    logic                        load_out;
    logic                        out_free;
    logic [WEIGHT_W-1:0]         w_sat;
    logic signed [SAMPLE_W:0]    x_sum;
    logic signed [SAMPLE_W:0]    y_sum;
    logic signed [DIFF_W-1:0]    head_diff;
    logic signed [SUM_W-1:0]     diff_ext;
    logic [CSCALE_W-1:0]         comp_scaled;
    logic signed [QUOT_W-1:0]    quot;
    logic signed [QUOT_W-1:0]    red_sum;
    logic [RED_W-1:0]            red_step;
    cordic_req_t                 cordic_req;
    cordic_res_t                 cordic_res;

    chcf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .res   (cordic_res)
    );

    // Operand preparation.
    assign w_sat       = (gyro_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : gyro_weight_reg;
    assign x_sum       = (SAMPLE_W+1)'(mag_x_reg) + (SAMPLE_W+1)'(mag_x_offset_reg);
    assign y_sum       = (SAMPLE_W+1)'(mag_y_reg) + (SAMPLE_W+1)'(mag_y_offset_reg);
    assign head_diff   = $signed(DIFF_W'(kept_reg)) - DIFF_W'(gyro_bias_reg);
    assign diff_ext    = SUM_W'(head_diff);
    assign comp_scaled = (CSCALE_W'(comp_reg) << 11) + (CSCALE_W'(comp_reg) << 9);
    assign quot        = $signed(acc_reg[ACC_W-1:UNIT_SHIFT]);
    assign red_sum     = quot + $signed(QUOT_W'(RED_OFFSET));
    assign red_step    = RED_MOD << red_cnt_reg;
    assign out_free    = !out_valid_reg || result.ready;
    assign prod        = mul_a * mul_b;

    // CORDIC request: start pulse and the scaled axes.
    assign cordic_req.start = (state_reg == ST_CSTART);
    assign cordic_req.x     = xs_reg;
    assign cordic_req.y     = ys_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_CSTART;
            ST_CSTART: state_next = ST_CWAIT;
            ST_CWAIT:
            begin
                if (cordic_res.done)
                begin
                    state_next = primed_reg ? ST_MUL_GYRO : ST_DONE;
                end
            end
            ST_MUL_GYRO: state_next = ST_MUL_COMP;
            ST_MUL_COMP: state_next = ST_ROUND;
            ST_ROUND:    state_next = ST_REDUCE;
            ST_REDUCE:
            begin
                if (red_cnt_reg == '0)
                begin
                    state_next = ST_DIV5;
                end
            end
            ST_DIV5: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes and multiplier operands.
    always_comb
    begin
        sample.ready     = (state_reg == ST_IDLE);
        load_out         = (state_reg == ST_DONE) && out_free;
        mul_a            = '0;
        mul_b            = '0;
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = MUL_A_W'(x_sum);
                mul_b = $signed(MUL_B_W'(mag_x_gain_reg));
            end
            ST_MUL_Y:
            begin
                mul_a = MUL_A_W'(y_sum);
                mul_b = $signed(MUL_B_W'(mag_y_gain_reg));
            end
            ST_CSTART:
            begin
                mul_a = MUL_A_W'(rate_reg);
                mul_b = RATE_FACTOR;
            end
            ST_MUL_GYRO:
            begin
                mul_a = sum_reg;
                mul_b = $signed(MUL_B_W'(w_sat));
            end
            ST_MUL_COMP:
            begin
                mul_a = $signed(MUL_A_W'(comp_scaled));
                mul_b = $signed(MUL_B_W'(WEIGHT_ONE - w_sat));
            end
            ST_DIV5:
            begin
                mul_a = $signed(MUL_A_W'(red_reg));
                mul_b = RECIP5;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = sample.valid && sample.ready;

    // Configuration writes; unknown indexes are ignored.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        mag_x_offset_next = mag_x_offset_reg;
        mag_x_gain_next   = mag_x_gain_reg;
        mag_y_offset_next = mag_y_offset_reg;
        mag_y_gain_next   = mag_y_gain_reg;
        gyro_bias_next    = gyro_bias_reg;
        gyro_weight_next  = gyro_weight_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAG_X_OFFSET: mag_x_offset_next = $signed(cfg.data[SAMPLE_W-1:0]);
                REG_MAG_X_GAIN:   mag_x_gain_next   = cfg.data[GAIN_W-1:0];
                REG_MAG_Y_OFFSET: mag_y_offset_next = $signed(cfg.data[SAMPLE_W-1:0]);
                REG_MAG_Y_GAIN:   mag_y_gain_next   = cfg.data[GAIN_W-1:0];
                REG_GYRO_BIAS:    gyro_bias_next    = $signed(cfg.data[SAMPLE_W-1:0]);
                REG_GYRO_WEIGHT:  gyro_weight_next  = cfg.data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Datapath: each state writes the register that its step produces.
    always_comb
    begin
        mag_x_next   = mag_x_reg;
        mag_y_next   = mag_y_reg;
        rate_next    = rate_reg;
        xs_next      = xs_reg;
        ys_next      = ys_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        red_next     = red_reg;
        red_cnt_next = red_cnt_reg;
        comp_next    = comp_reg;
        kept_next    = kept_reg;
        primed_next  = primed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_x_next = sample.mag_x;
                    mag_y_next = sample.mag_y;
                    rate_next  = sample.gyro_rate;
                end
            end
            ST_MUL_X: xs_next = AXIS_W'(prod <<< AXIS_SHIFT);
            ST_MUL_Y: ys_next = AXIS_W'(prod <<< AXIS_SHIFT);
            ST_CSTART:
            begin
                // Previous heading plus converted rate minus bias, all times 2560.
                sum_next = SUM_W'(prod) + (diff_ext <<< 11) + (diff_ext <<< 9);
            end
            ST_CWAIT:
            begin
                if (cordic_res.done)
                begin
                    comp_next = cordic_res.heading;
                    if (!primed_reg)
                    begin
                        kept_next   = cordic_res.heading;
                        primed_next = 1'b1;
                    end
                end
            end
            ST_MUL_GYRO: acc_next = ACC_W'(prod) + HALF_UNIT;
            ST_MUL_COMP: acc_next = acc_reg + ACC_W'(prod);
            ST_ROUND:
            begin
                red_next     = red_sum[RED_W-1:0];
                red_cnt_next = '1;
            end
            ST_REDUCE:
            begin
                // Restoring reduction by 8, 4, 2 and 1 times 115200.
                if (red_reg >= red_step)
                begin
                    red_next = red_reg - red_step;
                end
                red_cnt_next = red_cnt_reg - RED_CNT_W'(1);
            end
            ST_DIV5: kept_next = prod[RECIP_SHIFT +: HEAD_W];
            default:
            begin
            end
        endcase
    end

    // Output register: loads when free, clears when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_filt_next  = out_filt_reg;
        out_comp_next  = out_comp_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_filt_next  = kept_reg;
            out_comp_next  = comp_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.filtered_heading = out_filt_reg;
    assign result.compass_heading  = out_comp_reg;

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kept_reg         <= '0;
            primed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            mag_x_offset_reg <= MAG_X_OFFSET_RST;
            mag_x_gain_reg   <= MAG_X_GAIN_RST;
            mag_y_offset_reg <= MAG_Y_OFFSET_RST;
            mag_y_gain_reg   <= MAG_Y_GAIN_RST;
            gyro_bias_reg    <= GYRO_BIAS_RST;
            gyro_weight_reg  <= GYRO_WEIGHT_RST;
            red_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            kept_reg         <= kept_next;
            primed_reg       <= primed_next;
            out_valid_reg    <= out_valid_next;
            mag_x_offset_reg <= mag_x_offset_next;
            mag_x_gain_reg   <= mag_x_gain_next;
            mag_y_offset_reg <= mag_y_offset_next;
            mag_y_gain_reg   <= mag_y_gain_next;
            gyro_bias_reg    <= gyro_bias_next;
            gyro_weight_reg  <= gyro_weight_next;
            red_cnt_reg      <= red_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_x_reg    <= mag_x_next;
        mag_y_reg    <= mag_y_next;
        rate_reg     <= rate_next;
        xs_reg       <= xs_next;
        ys_reg       <= ys_next;
        sum_reg      <= sum_next;
        acc_reg      <= acc_next;
        red_reg      <= red_next;
        comp_reg     <= comp_next;
        out_filt_reg <= out_filt_next;
        out_comp_reg <= out_comp_next;
    end

endmodule

[src/chcf_checker.sv]
// Port-level checks for the compass heading complementary filter, and the
// bind that attaches them to the top level. Depends on chcf_pkg.
module chcf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sample_valid,
    input logic                        sample_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [chcf_pkg::HEAD_W-1:0] filtered_heading,
    input logic [chcf_pkg::HEAD_W-1:0] compass_heading
);
    import chcf_pkg::*;

    // A pending result stays offered until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped before it was taken");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(filtered_heading) && $stable(compass_heading))
        else $error("stalled result payload changed");

    // Both headings lie within one full circle.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (filtered_heading < DEG360_Q64) && (compass_heading < DEG360_Q64))
        else $error("heading outside one full circle");

    // A sample occupies the block: no second sample in the following cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample accepted while another is in progress");

endmodule

bind compass_heading_complementary_filter_core chcf_checker u_chcf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_valid     (sample.valid),
    .sample_ready     (sample.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .filtered_heading (result.filtered_heading),
    .compass_heading  (result.compass_heading)
);
